// ===== rtl/core/tlpm_pkg.sv =====
`timescale 1ns / 1ps

package tlpm_pkg;

    // frame window size, the field widths and the widths that follow from them
    localparam int STORE_FRAMES = 64;
    localparam int ENTRY_W      = 10;
    localparam int FRAME_W      = 20;
    localparam int WORD_W       = 32;
    localparam int SLOT_W       = (STORE_FRAMES > 1) ? $clog2(STORE_FRAMES) : 1;
    localparam int USED_W       = $clog2(STORE_FRAMES + 1);
    localparam int ADDR_W       = SLOT_W + ENTRY_W;
    localparam int UPC_W        = 5;

    typedef logic [UPC_W-1:0] upc_t;

    // operation codes
    localparam logic [1:0] FUNC_MAP    = 2'd0;
    localparam logic [1:0] FUNC_UNMAP  = 2'd1;
    localparam logic [1:0] FUNC_NEWDIR = 2'd2;

    // status codes
    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_DIR_OUT   = 2'd1;
    localparam logic [1:0] ST_EXHAUSTED = 2'd2;
    localparam logic [1:0] ST_TBL_OUT   = 2'd3;

    typedef struct packed {
        logic [1:0]         func;
        logic [FRAME_W-1:0] dir_page;
        logic [WORD_W-1:0]  virt_addr;
        logic [WORD_W-1:0]  phys_addr;
        logic               writable;
        logic               user;
    } in_item_t;

    typedef struct packed {
        logic [1:0]         status;
        logic               table_allocated;
        logic               entry_absent;
        logic [FRAME_W-1:0] new_dir_page;
        logic [WORD_W-1:0]  dir_entry;
        logic [WORD_W-1:0]  table_entry;
    } out_item_t;

    // datapath action of one microcode step
    typedef enum logic [3:0] {
        OP_NOP,
        OP_LATCH,
        OP_DIR_CHK,
        OP_RD_DE,
        OP_LD_DE,
        OP_ALLOC_T,
        OP_CLR_T,
        OP_WR_TE,
        OP_TBL_CHK,
        OP_ABSENT,
        OP_FULL,
        OP_ALLOC_D,
        OP_ALLOC_T2,
        OP_CLR_D,
        OP_FILL_T,
        OP_EMIT
    } op_t;

    // jump condition of one microcode step
    typedef enum logic [3:0] {
        C_NEVER,
        C_ALWAYS,
        C_NO_INPUT,
        C_FUNC_NEW,
        C_FUNC_BAD,
        C_FUNC_UNMAP,
        C_DIR_OUT,
        C_PRESENT,
        C_FULL1,
        C_FULL2,
        C_TBL_OUT,
        C_CNT_MORE,
        C_OUT_FREE
    } cond_t;

    typedef struct packed {
        op_t   op;
        cond_t cond;
        upc_t  target;
    } ctrl_word_t;

    typedef struct packed {
        logic in_valid;
        logic out_free;
        logic func_new;
        logic func_bad;
        logic func_unmap;
        logic dir_out;
        logic present;
        logic full1;
        logic full2;
        logic tbl_out;
        logic cnt_more;
    } flags_t;

endpackage

// ===== rtl/core/tlpm_store.sv =====
`timescale 1ns / 1ps

module tlpm_store (
    input  logic                         aclk,
    input  logic                         we,
    input  logic                         re,
    input  logic [tlpm_pkg::ADDR_W-1:0]  addr,
    input  logic [tlpm_pkg::WORD_W-1:0]  wdata,
    output logic [tlpm_pkg::WORD_W-1:0]  rdata
);
    import tlpm_pkg::*;

    logic [WORD_W-1:0] mem [STORE_FRAMES * (2 ** ENTRY_W)];
    logic [WORD_W-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[addr] <= wdata;
        end
    end

    always_ff @(posedge aclk) begin
        if (re) begin
            rdata_reg <= mem[addr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== rtl/core/tlpm_useq.sv =====
`timescale 1ns / 1ps

module tlpm_useq (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  tlpm_pkg::flags_t     flags,
    output tlpm_pkg::ctrl_word_t ctrl
);
    import tlpm_pkg::*;

    // entry points of the program
    localparam upc_t S_FETCH   = 5'd0;
    localparam upc_t S_CLR_T   = 5'd9;
    localparam upc_t S_PRESENT = 5'd11;
    localparam upc_t S_WR_TE   = 5'd12;
    localparam upc_t S_ABSENT  = 5'd13;
    localparam upc_t S_FULL    = 5'd14;
    localparam upc_t S_NEWDIR  = 5'd15;
    localparam upc_t S_CLR_D   = 5'd18;
    localparam upc_t S_FILL_T  = 5'd19;
    localparam upc_t S_FINISH  = 5'd20;

    function automatic ctrl_word_t rom(input upc_t pc);
        ctrl_word_t w;
        w = '{op: OP_NOP, cond: C_ALWAYS, target: S_FETCH};
        unique case (pc)
            5'd0:  w = '{op: OP_LATCH,    cond: C_NO_INPUT,   target: S_FETCH};
            5'd1:  w = '{op: OP_NOP,      cond: C_FUNC_NEW,   target: S_NEWDIR};
            5'd2:  w = '{op: OP_NOP,      cond: C_FUNC_BAD,   target: S_FINISH};
            5'd3:  w = '{op: OP_DIR_CHK,  cond: C_DIR_OUT,    target: S_FINISH};
            5'd4:  w = '{op: OP_RD_DE,    cond: C_NEVER,      target: S_FETCH};
            5'd5:  w = '{op: OP_LD_DE,    cond: C_PRESENT,    target: S_PRESENT};
            5'd6:  w = '{op: OP_NOP,      cond: C_FUNC_UNMAP, target: S_ABSENT};
            5'd7:  w = '{op: OP_NOP,      cond: C_FULL1,      target: S_FULL};
            5'd8:  w = '{op: OP_ALLOC_T,  cond: C_NEVER,      target: S_FETCH};
            5'd9:  w = '{op: OP_CLR_T,    cond: C_CNT_MORE,   target: S_CLR_T};
            5'd10: w = '{op: OP_NOP,      cond: C_ALWAYS,     target: S_WR_TE};
            5'd11: w = '{op: OP_TBL_CHK,  cond: C_TBL_OUT,    target: S_FINISH};
            5'd12: w = '{op: OP_WR_TE,    cond: C_ALWAYS,     target: S_FINISH};
            5'd13: w = '{op: OP_ABSENT,   cond: C_ALWAYS,     target: S_FINISH};
            5'd14: w = '{op: OP_FULL,     cond: C_ALWAYS,     target: S_FINISH};
            5'd15: w = '{op: OP_NOP,      cond: C_FULL2,      target: S_FULL};
            5'd16: w = '{op: OP_ALLOC_D,  cond: C_NEVER,      target: S_FETCH};
            5'd17: w = '{op: OP_ALLOC_T2, cond: C_NEVER,      target: S_FETCH};
            5'd18: w = '{op: OP_CLR_D,    cond: C_CNT_MORE,   target: S_CLR_D};
            5'd19: w = '{op: OP_FILL_T,   cond: C_CNT_MORE,   target: S_FILL_T};
            5'd20: w = '{op: OP_EMIT,     cond: C_OUT_FREE,   target: S_FETCH};
            5'd21: w = '{op: OP_NOP,      cond: C_ALWAYS,     target: S_FINISH};
            default: w = '{op: OP_NOP,    cond: C_ALWAYS,     target: S_FETCH};
        endcase
        return w;
    endfunction

    upc_t upc_reg;
    upc_t upc_next;
    logic take;

    assign ctrl = rom(upc_reg);

    always_comb begin
        unique case (ctrl.cond)
            C_NEVER:      take = 1'b0;
            C_ALWAYS:     take = 1'b1;
            C_NO_INPUT:   take = !flags.in_valid;
            C_FUNC_NEW:   take = flags.func_new;
            C_FUNC_BAD:   take = flags.func_bad;
            C_FUNC_UNMAP: take = flags.func_unmap;
            C_DIR_OUT:    take = flags.dir_out;
            C_PRESENT:    take = flags.present;
            C_FULL1:      take = flags.full1;
            C_FULL2:      take = flags.full2;
            C_TBL_OUT:    take = flags.tbl_out;
            C_CNT_MORE:   take = flags.cnt_more;
            C_OUT_FREE:   take = flags.out_free;
            default:      take = 1'b1;
        endcase
        upc_next = take ? ctrl.target : upc_reg + upc_t'(1);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            upc_reg <= S_FETCH;
        end else begin
            upc_reg <= upc_next;
        end
    end

endmodule

// ===== rtl/core/tlpm_dpath.sv =====
`timescale 1ns / 1ps

module tlpm_dpath (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  tlpm_pkg::ctrl_word_t         ctrl,
    input  logic                         s_valid,
    input  tlpm_pkg::in_item_t           s_data,
    input  logic                         out_free,
    input  logic                         cfg_we,
    input  logic [tlpm_pkg::FRAME_W-1:0] cfg_data,
    output tlpm_pkg::flags_t             flags,
    output tlpm_pkg::out_item_t          result
);
    import tlpm_pkg::*;

    localparam logic [11:0]        KERNEL_ATTR = 12'h003;
    localparam logic [FRAME_W-1:0] BASE_RESET  = 20'd256;

    in_item_t            item_reg,   item_next;
    logic [1:0]          status_reg, status_next;
    logic                talloc_reg, talloc_next;
    logic                absent_reg, absent_next;
    logic [FRAME_W-1:0]  ndir_reg,   ndir_next;
    logic [WORD_W-1:0]   de_reg,     de_next;
    logic [WORD_W-1:0]   te_reg,     te_next;
    logic [SLOT_W-1:0]   dslot_reg,  dslot_next;
    logic [SLOT_W-1:0]   tslot_reg,  tslot_next;
    logic [ENTRY_W-1:0]  cnt_reg,    cnt_next;
    logic [USED_W-1:0]   used_reg,   used_next;
    logic [FRAME_W-1:0]  base_reg,   base_next;

    logic                mem_we;
    logic                mem_re;
    logic [ADDR_W-1:0]   mem_addr;
    logic [WORD_W-1:0]   mem_wdata;
    logic [WORD_W-1:0]   rdata;

    logic [FRAME_W-1:0]  dir_off;
    logic [FRAME_W-1:0]  tbl_off;
    logic [FRAME_W-1:0]  new_frame;
    logic [ENTRY_W-1:0]  di;
    logic [ENTRY_W-1:0]  ti;
    logic [WORD_W-1:0]   new_de;
    logic [WORD_W-1:0]   te_val;
    logic                dir_out;
    logic                tbl_out;

    tlpm_store u_store (
        .aclk  (aclk),
        .we    (mem_we),
        .re    (mem_re),
        .addr  (mem_addr),
        .wdata (mem_wdata),
        .rdata (rdata)
    );

    // window offsets wrap modulo the frame number space
    assign dir_off   = item_reg.dir_page - base_reg;
    assign tbl_off   = de_reg[WORD_W-1:12] - base_reg;
    assign dir_out   = !(dir_off < FRAME_W'(used_reg));
    assign tbl_out   = !(tbl_off < FRAME_W'(used_reg));
    assign new_frame = base_reg + FRAME_W'(used_reg);
    assign di        = item_reg.virt_addr[31:22];
    assign ti        = item_reg.virt_addr[21:12];
    assign new_de    = {new_frame, 9'd0, item_reg.user, item_reg.writable, 1'b1};
    assign te_val    = (item_reg.func == FUNC_MAP)
                     ? {item_reg.phys_addr[31:12], 9'd0, item_reg.user,
                        item_reg.writable, 1'b1}
                     : '0;

    always_comb begin
        item_next   = item_reg;
        status_next = status_reg;
        talloc_next = talloc_reg;
        absent_next = absent_reg;
        ndir_next   = ndir_reg;
        de_next     = de_reg;
        te_next     = te_reg;
        dslot_next  = dslot_reg;
        tslot_next  = tslot_reg;
        cnt_next    = cnt_reg;
        used_next   = used_reg;
        base_next   = cfg_we ? cfg_data : base_reg;
        mem_we      = 1'b0;
        mem_re      = 1'b0;
        mem_addr    = {dslot_reg, cnt_reg};
        mem_wdata   = '0;
        unique case (ctrl.op)
            OP_NOP, OP_EMIT: begin
            end
            OP_LATCH: begin
                if (s_valid) begin
                    item_next   = s_data;
                    status_next = ST_OK;
                    talloc_next = 1'b0;
                    absent_next = 1'b0;
                    ndir_next   = '0;
                    de_next     = '0;
                    te_next     = '0;
                    cnt_next    = '0;
                end
            end
            OP_DIR_CHK: begin
                dslot_next = dir_off[SLOT_W-1:0];
                if (dir_out) begin
                    status_next = ST_DIR_OUT;
                end
            end
            OP_RD_DE: begin
                mem_re   = 1'b1;
                mem_addr = {dslot_reg, di};
            end
            OP_LD_DE: begin
                de_next = rdata;
            end
            OP_ALLOC_T: begin
                tslot_next  = used_reg[SLOT_W-1:0];
                used_next   = used_reg + USED_W'(1);
                de_next     = new_de;
                talloc_next = 1'b1;
                cnt_next    = '0;
                mem_we      = 1'b1;
                mem_addr    = {dslot_reg, di};
                mem_wdata   = new_de;
            end
            OP_CLR_T: begin
                mem_we   = 1'b1;
                mem_addr = {tslot_reg, cnt_reg};
                cnt_next = cnt_reg + ENTRY_W'(1);
            end
            OP_WR_TE: begin
                te_next   = te_val;
                mem_we    = 1'b1;
                mem_addr  = {tslot_reg, ti};
                mem_wdata = te_val;
            end
            OP_TBL_CHK: begin
                tslot_next = tbl_off[SLOT_W-1:0];
                if (tbl_out) begin
                    status_next = ST_TBL_OUT;
                end
            end
            OP_ABSENT: begin
                absent_next = 1'b1;
            end
            OP_FULL: begin
                status_next = ST_EXHAUSTED;
            end
            OP_ALLOC_D: begin
                dslot_next = used_reg[SLOT_W-1:0];
                used_next  = used_reg + USED_W'(1);
                ndir_next  = new_frame;
                cnt_next   = '0;
            end
            OP_ALLOC_T2: begin
                tslot_next  = used_reg[SLOT_W-1:0];
                used_next   = used_reg + USED_W'(1);
                de_next     = {new_frame, KERNEL_ATTR};
                te_next     = WORD_W'(KERNEL_ATTR);
                talloc_next = 1'b1;
                cnt_next    = '0;
            end
            OP_CLR_D: begin
                // entry 0 takes the new table, the rest is cleared
                mem_we    = 1'b1;
                mem_addr  = {dslot_reg, cnt_reg};
                mem_wdata = (cnt_reg == '0) ? de_reg : '0;
                cnt_next  = cnt_reg + ENTRY_W'(1);
            end
            OP_FILL_T: begin
                mem_we    = 1'b1;
                mem_addr  = {tslot_reg, cnt_reg};
                mem_wdata = {{(FRAME_W - ENTRY_W){1'b0}}, cnt_reg, KERNEL_ATTR};
                cnt_next  = cnt_reg + ENTRY_W'(1);
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            used_reg <= '0;
            base_reg <= BASE_RESET;
        end else begin
            used_reg <= used_next;
            base_reg <= base_next;
        end
        item_reg   <= item_next;
        status_reg <= status_next;
        talloc_reg <= talloc_next;
        absent_reg <= absent_next;
        ndir_reg   <= ndir_next;
        de_reg     <= de_next;
        te_reg     <= te_next;
        dslot_reg  <= dslot_next;
        tslot_reg  <= tslot_next;
        cnt_reg    <= cnt_next;
    end

    always_comb begin
        flags.in_valid   = s_valid;
        flags.out_free   = out_free;
        flags.func_new   = (item_reg.func == FUNC_NEWDIR);
        flags.func_unmap = (item_reg.func == FUNC_UNMAP);
        flags.func_bad   = !((item_reg.func == FUNC_MAP) || (item_reg.func == FUNC_UNMAP)
                             || (item_reg.func == FUNC_NEWDIR));
        flags.dir_out    = dir_out;
        flags.present    = rdata[0];
        flags.full1      = (used_reg >= USED_W'(STORE_FRAMES));
        flags.full2      = (({1'b0, used_reg} + (USED_W + 1)'(2))
                            > (USED_W + 1)'(STORE_FRAMES));
        flags.tbl_out    = tbl_out;
        flags.cnt_more   = (cnt_reg != '1);
    end

    assign result.status          = status_reg;
    assign result.table_allocated = talloc_reg;
    assign result.entry_absent    = absent_reg;
    assign result.new_dir_page    = ndir_reg;
    assign result.dir_entry       = de_reg;
    assign result.table_entry     = te_reg;

endmodule

// ===== rtl/core/two_level_page_table_mapper.sv =====
`timescale 1ns / 1ps

// two-level x86-style page table mapper: keeps a window of STORE_FRAMES page
// frames of 1024 words each in a single-port store and serves map, unmap and
// new-directory requests, one word at a time. a short microcode program
// drives the datapath; control is one step per clock. map or unmap through a
// present directory entry, and unmap through an absent one, runs the fetch,
// func and window checks and the directory read, then a table window check
// and entry write or the absent mark, then the emit step, which returns to
// fetch for the next word. map that allocates a table first clears the new
// table, one store write per entry, and new-directory clears the directory
// and fills the table with an identity map. an out-of-window directory and
// the unused func code go straight to the emit step. the next input word is
// taken once the result is in the output register, so a waiting result does
// not hold up the next request. the window base is written through the cfg
// port, which is always ready; write it only while the block is idle. the
// store has no reset: only allocated, hence cleared, frames are ever read.

module two_level_page_table_mapper (
    input  logic                         aclk,
    input  logic                         aresetn,
    // request channel
    input  logic                         s_valid,
    output logic                         s_ready,
    input  tlpm_pkg::in_item_t           s_data,
    // result channel
    output logic                         m_valid,
    input  logic                         m_ready,
    output tlpm_pkg::out_item_t          m_data,
    // window base register
    input  logic                         cfg_valid,
    output logic                         cfg_ready,
    input  logic [tlpm_pkg::FRAME_W-1:0] cfg_data
);
    import tlpm_pkg::*;

    ctrl_word_t ctrl;
    flags_t     flags;
    out_item_t  result;

    logic       out_free;
    logic       emit;

    logic       m_valid_reg, m_valid_next;
    out_item_t  m_data_reg,  m_data_next;

    // microcode sequencer: step counter, program rom, conditional jumps
    tlpm_useq u_useq (
        .aclk    (aclk),
        .aresetn (aresetn),
        .flags   (flags),
        .ctrl    (ctrl)
    );

    // datapath with the frame store, allocator and window checks
    tlpm_dpath u_dpath (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .ctrl     (ctrl),
        .s_valid  (s_valid),
        .s_data   (s_data),
        .out_free (out_free),
        .cfg_we   (cfg_valid),
        .cfg_data (cfg_data),
        .flags    (flags),
        .result   (result)
    );

    // the fetch step is the only one that takes a request word
    assign s_ready   = (ctrl.op == OP_LATCH);
    assign cfg_ready = 1'b1;

    // output register frees up in the same cycle it is taken
    assign out_free = !m_valid_reg || m_ready;
    assign emit     = (ctrl.op == OP_EMIT) && out_free;

    always_comb begin
        m_valid_next = m_valid_reg;
        m_data_next  = m_data_reg;
        if (emit) begin
            m_valid_next = 1'b1;
            m_data_next  = result;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
        m_data_reg <= m_data_next;
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 1ps

module tb;
    import tlpm_pkg::*;

    // run limits and stimulus shape
    localparam int unsigned CYCLE_LIMIT    = 1_500_000;
    localparam int unsigned PAGE_WORDS     = 1024;
    localparam int unsigned PHASE_ITEMS    = 475;
    localparam int unsigned BURST          = 16;
    localparam int unsigned SQUEEZE_EVERY  = 700;
    localparam int unsigned SQUEEZE_CYCLES = 400;
    localparam int unsigned MAX_PRINTS     = 40;

    // the fourth func code is left unused by the block
    localparam logic [1:0] FUNC_SPARE = 2'd3;

    // x86 entry attribute bits
    localparam logic [WORD_W-1:0] PTE_PRESENT = 32'h0000_0001;
    localparam logic [WORD_W-1:0] PTE_WRITE   = 32'h0000_0002;
    localparam logic [WORD_W-1:0] PTE_USER    = 32'h0000_0004;

    localparam logic [FRAME_W-1:0] RESET_BASE = 20'h00100;

    logic               aclk;
    logic               aresetn   = 1'b0;
    logic               s_valid   = 1'b0;
    logic               s_ready;
    in_item_t           s_data    = '0;
    logic               m_valid;
    logic               m_ready   = 1'b0;
    out_item_t          m_data;
    logic               cfg_valid = 1'b0;
    logic               cfg_ready;
    logic [FRAME_W-1:0] cfg_data  = '0;

    // shadow of the frame store, the bump allocator and the window base
    logic [WORD_W-1:0]  page_mem [STORE_FRAMES*PAGE_WORDS];
    int unsigned        frames_taken = 0;
    logic [FRAME_W-1:0] win_base     = RESET_BASE;
    int unsigned        dir_slots[$];

    in_item_t           req_backlog[$];
    out_item_t          due_results[$];

    int unsigned        error_count  = 0;
    int unsigned        results_seen = 0;
    int unsigned        cycle_count  = 0;
    int unsigned        send_gap     = 0;
    int unsigned        hold_left    = 0;
    bit                 send_busy;
    bit                 calm         = 1'b0;

    two_level_page_table_mapper i_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_valid  (s_valid),
        .s_ready  (s_ready),
        .s_data   (s_data),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .m_data   (m_data),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_data (cfg_data)
    );

    initial begin
        aclk = 1'b0;
        forever #6 aclk = ~aclk;
    end

    // ------------------------------------------------------------------
    // page walk prediction
    // ------------------------------------------------------------------

    // frame lies in the window when its distance from the base, modulo
    // 2^20, is below the number of frames handed out so far
    function automatic bit in_window(input logic [FRAME_W-1:0] frame,
                                     output int unsigned slot);
        logic [FRAME_W-1:0] off;
        off  = frame - win_base;
        slot = off;
        return off < frames_taken;
    endfunction

    // bump allocator: next slot, cleared, returned as a physical frame
    function automatic logic [FRAME_W-1:0] grab_frame(output int unsigned slot);
        slot = frames_taken;
        for (int i = 0; i < PAGE_WORDS; i++) page_mem[slot*PAGE_WORDS + i] = '0;
        frames_taken++;
        return win_base + FRAME_W'(slot);
    endfunction

    function automatic out_item_t predict_walk(input in_item_t req);
        out_item_t          r;
        logic [ENTRY_W-1:0] di;
        logic [ENTRY_W-1:0] ti;
        logic [WORD_W-1:0]  attr;
        logic [FRAME_W-1:0] tf;
        logic [FRAME_W-1:0] df;
        int unsigned        dslot;
        int unsigned        tslot;
        r     = '0;
        di    = req.virt_addr[31:22];
        ti    = req.virt_addr[21:12];
        attr  = (req.writable ? PTE_WRITE : '0) | (req.user ? PTE_USER : '0);
        tslot = 0;
        case (req.func)
            FUNC_MAP, FUNC_UNMAP: begin
                if (!in_window(req.dir_page, dslot)) begin
                    r.status = ST_DIR_OUT;
                end else begin
                    r.dir_entry = page_mem[dslot*PAGE_WORDS + di];
                    if (r.dir_entry[0]) begin
                        // present entry pointing outside the window is left alone
                        if (!in_window(r.dir_entry[31:12], tslot)) r.status = ST_TBL_OUT;
                    end else if (req.func == FUNC_UNMAP) begin
                        r.entry_absent = 1'b1;
                    end else if (frames_taken >= STORE_FRAMES) begin
                        r.status = ST_EXHAUSTED;
                    end else begin
                        tf = grab_frame(tslot);
                        r.dir_entry = {tf, 12'h000} | attr | PTE_PRESENT;
                        page_mem[dslot*PAGE_WORDS + di] = r.dir_entry;
                        r.table_allocated = 1'b1;
                    end
                    if (r.status == ST_OK && !r.entry_absent) begin
                        r.table_entry = (req.func == FUNC_MAP) ?
                            ({req.phys_addr[31:12], 12'h000} | attr | PTE_PRESENT) : '0;
                        page_mem[tslot*PAGE_WORDS + ti] = r.table_entry;
                    end
                end
            end
            FUNC_NEWDIR: begin
                if (frames_taken + 2 > STORE_FRAMES) begin
                    r.status = ST_EXHAUSTED;
                end else begin
                    df = grab_frame(dslot);
                    tf = grab_frame(tslot);
                    r.dir_entry = {tf, 12'h000} | PTE_WRITE | PTE_PRESENT;
                    page_mem[dslot*PAGE_WORDS] = r.dir_entry;
                    // identity map of the first 4 MiB, supervisor and writable
                    for (int i = 0; i < PAGE_WORDS; i++)
                        page_mem[tslot*PAGE_WORDS + i] =
                            (WORD_W'(i) << 12) | PTE_WRITE | PTE_PRESENT;
                    r.table_entry     = PTE_WRITE | PTE_PRESENT;
                    r.new_dir_page    = df;
                    r.table_allocated = 1'b1;
                    dir_slots.push_back(dslot);
                end
            end
            default: r = '0;
        endcase
        return r;
    endfunction

    // ------------------------------------------------------------------
    // stimulus helpers
    // ------------------------------------------------------------------

    function automatic in_item_t mk_req(input logic [1:0] f, input logic [FRAME_W-1:0] dir,
                                        input logic [WORD_W-1:0] va,
                                        input logic [WORD_W-1:0] pa,
                                        input logic w, input logic u);
        in_item_t r;
        r.func      = f;
        r.dir_page  = dir;
        r.virt_addr = va;
        r.phys_addr = pa;
        r.writable  = w;
        r.user      = u;
        return r;
    endfunction

    // mostly walks through known directories on a handful of directory
    // slots, so that maps land on present tables and unmaps find something
    function automatic in_item_t make_request();
        in_item_t    r;
        int unsigned pick;
        int unsigned di;
        int unsigned ti;
        pick = $urandom_range(0, 99);
        if (pick < 50)      r.func = FUNC_MAP;
        else if (pick < 94) r.func = FUNC_UNMAP;
        else if (pick < 98) r.func = FUNC_NEWDIR;
        else                r.func = FUNC_SPARE;
        pick = $urandom_range(0, 99);
        if (pick < 70 && dir_slots.size() != 0)
            r.dir_page = win_base + FRAME_W'(dir_slots[$urandom_range(0, dir_slots.size() - 1)]);
        else if (pick < 85 && frames_taken != 0)
            r.dir_page = win_base + FRAME_W'($urandom_range(0, frames_taken - 1));
        else
            r.dir_page = FRAME_W'($urandom());
        pick = $urandom_range(0, 99);
        if (pick < 50)      di = 0;
        else if (pick < 80) di = $urandom_range(1, 3);
        else                di = $urandom_range(0, PAGE_WORDS - 1);
        ti = $urandom_range(0, 1) ? $urandom_range(0, 7) : $urandom_range(0, PAGE_WORDS - 1);
        r.virt_addr = {10'(di), 10'(ti), 12'($urandom())};
        r.phys_addr = $urandom();
        r.writable  = $urandom_range(0, 1);
        r.user      = $urandom_range(0, 1);
        return r;
    endfunction

    // idle length for either side: mostly none, sometimes a long gap
    function automatic int unsigned idle_len();
        int unsigned r;
        if (calm) return 0;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 88) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 80);
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        error_count++;
        if (error_count <= MAX_PRINTS)
            $display("mismatch at result %0d: %s got %h want %h",
                     results_seen, what, got, want);
    endtask

    task automatic match_field(input string what, input logic [31:0] got,
                               input logic [31:0] want);
        if (got !== want) report_mismatch(what, got, want);
    endtask

    // ------------------------------------------------------------------
    // request driver: pops the backlog, predicts each word as it is taken
    // ------------------------------------------------------------------
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
            send_gap = 0;
        end else begin
            send_busy = s_valid;
            if (s_valid && s_ready) begin
                due_results.push_back(predict_walk(s_data));
                send_busy = 1'b0;
                send_gap  = idle_len();
            end
            // valid is only touched once per edge, and never while a word waits
            if (!send_busy) begin
                if (send_gap > 0) begin
                    send_gap--;
                    s_valid <= 1'b0;
                end else if (req_backlog.size() != 0) begin
                    s_data  <= req_backlog.pop_front();
                    s_valid <= 1'b1;
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // result monitor with back-pressure; every SQUEEZE_EVERY results the
    // receiver holds off long enough for the block to back up its input
    // ------------------------------------------------------------------
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
            hold_left = 0;
        end else begin
            if (m_valid && m_ready) begin
                if (due_results.size() == 0) begin
                    report_mismatch("result word with nothing due", m_data.dir_entry, '0);
                end else begin
                    match_field("status", m_data.status, due_results[0].status);
                    match_field("table_allocated", m_data.table_allocated,
                                due_results[0].table_allocated);
                    match_field("entry_absent", m_data.entry_absent,
                                due_results[0].entry_absent);
                    match_field("new_dir_page", m_data.new_dir_page,
                                due_results[0].new_dir_page);
                    match_field("dir_entry", m_data.dir_entry, due_results[0].dir_entry);
                    match_field("table_entry", m_data.table_entry,
                                due_results[0].table_entry);
                    void'(due_results.pop_front());
                end
                results_seen++;
                hold_left = (results_seen % SQUEEZE_EVERY == SQUEEZE_EVERY / 2) ?
                            SQUEEZE_CYCLES : idle_len();
            end
            if (hold_left > 0) begin
                hold_left--;
                m_ready <= 1'b0;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    // watchdog
    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    // wait for the block to go quiet: nothing queued, nothing offered,
    // nothing owed
    task automatic drain();
        while (req_backlog.size() != 0 || s_valid || due_results.size() != 0)
            @(posedge aclk);
    endtask

    // window base write, only ever issued while the block is idle
    task automatic set_base(input logic [FRAME_W-1:0] v);
        cfg_data  <= v;
        cfg_valid <= 1'b1;
        do @(posedge aclk); while (!(cfg_valid && cfg_ready));
        cfg_valid <= 1'b0;
        win_base = v;
    endtask

    // ------------------------------------------------------------------
    // sequence: reset, directed walks, then random phases over several
    // window bases (zero, top of the frame space with wrap, random, reset)
    // ------------------------------------------------------------------
    initial begin
        logic [FRAME_W-1:0] base_plan [4];
        logic [FRAME_W-1:0] b;
        base_plan = '{20'h00000, 20'hFFFFF, 20'h00000, RESET_BASE};
        base_plan[2] = FRAME_W'($urandom_range(1, 20'hFFFFE));
        b = RESET_BASE;

        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        set_base(b);

        // empty window: every directory is outside
        req_backlog.push_back(mk_req(FUNC_MAP, b, '0, 32'h0000_1000, 1'b1, 1'b0));
        req_backlog.push_back(mk_req(FUNC_UNMAP, '1, '1, '1, 1'b1, 1'b1));
        // unused func code with every other field at its top
        req_backlog.push_back(mk_req(FUNC_SPARE, '1, '1, '1, 1'b1, 1'b1));
        // first directory at b, its identity table at b+1
        req_backlog.push_back(mk_req(FUNC_NEWDIR, '0, '0, '0, 1'b0, 1'b0));
        // absent entry: table allocated, then an existing entry keeps its attributes
        req_backlog.push_back(mk_req(FUNC_MAP, b, 32'h0040_0000, '1, 1'b1, 1'b1));
        req_backlog.push_back(mk_req(FUNC_MAP, b, 32'h0040_1000, 32'hABCD_E123, 1'b0, 1'b0));
        // overwrite inside the identity table
        req_backlog.push_back(mk_req(FUNC_MAP, b, 32'h0000_0000, 32'h1234_5000, 1'b1, 1'b0));
        req_backlog.push_back(mk_req(FUNC_UNMAP, b, 32'h0040_0000, '0, 1'b0, 1'b0));
        // unmap through an absent directory entry
        req_backlog.push_back(mk_req(FUNC_UNMAP, b, 32'hFFC0_0000, '0, 1'b1, 1'b1));
        req_backlog.push_back(mk_req(FUNC_MAP, b, '1, '0, 1'b0, 1'b1));
        // identity table used as a directory: low frames fall outside the window
        req_backlog.push_back(mk_req(FUNC_MAP, b + 20'd1, 32'h0040_0000, '1, 1'b1, 1'b1));
        // ...while entry 256 points back at the first directory
        req_backlog.push_back(mk_req(FUNC_MAP, b + 20'd1, 32'h4000_5000, 32'h8000_0000,
                                     1'b1, 1'b1));
        // just past the window on both sides
        req_backlog.push_back(mk_req(FUNC_MAP, b + 20'd4, '0, '0, 1'b0, 1'b0));
        req_backlog.push_back(mk_req(FUNC_UNMAP, b - 20'd1, '0, '0, 1'b0, 1'b0));
        // second directory at b+4, table at b+5
        req_backlog.push_back(mk_req(FUNC_NEWDIR, '1, '1, '1, 1'b1, 1'b1));
        req_backlog.push_back(mk_req(FUNC_UNMAP, b + 20'd4, 32'h0000_0000, '0, 1'b0, 1'b0));
        req_backlog.push_back(mk_req(FUNC_MAP, b + 20'd4, 32'h0000_3FFF, 32'hFFFF_F000,
                                     1'b0, 1'b1));
        req_backlog.push_back(mk_req(FUNC_SPARE, '0, '0, '0, 1'b0, 1'b0));
        drain();

        for (int p = 0; p < 4; p++) begin
            set_base(base_plan[p]);
            // one phase runs both sides without idling
            calm <= (p == 1);
            for (int n = 0; n < PHASE_ITEMS; n += BURST) begin
                for (int k = 0; k < BURST; k++) req_backlog.push_back(make_request());
                while (req_backlog.size() != 0) @(posedge aclk);
            end
            drain();
        end

        // let any stray result word show up before judging
        repeat (40) @(posedge aclk);
        if (due_results.size() != 0)
            report_mismatch("results never delivered", due_results.size(), '0);
        if (error_count == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/core/tlpm_pkg.sv
rtl/core/tlpm_store.sv
rtl/core/tlpm_useq.sv
rtl/core/tlpm_dpath.sv
rtl/core/two_level_page_table_mapper.sv
tb/tb.sv
